FILE: rtl/int8_register_stack_execute_assert.svh
// assertion macros shared by the rtl, sampled on clock and disabled in reset
`ifndef INT8_REGISTER_STACK_EXECUTE_ASSERT_SVH
`define INT8_REGISTER_STACK_EXECUTE_ASSERT_SVH

// same-cycle implication
`define I8RSE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i8rse same-cycle check failed");

// next-cycle implication
`define I8RSE_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i8rse next-cycle check failed");

`endif

FILE: rtl/i8rse_pkg.sv
`default_nettype none

package i8rse_pkg;

   // instruction codes
   localparam logic [4:0] CMD_MOV    = 5'd0;
   localparam logic [4:0] CMD_MOV_R  = 5'd1;
   localparam logic [4:0] CMD_MOVS   = 5'd2;
   localparam logic [4:0] CMD_PUSH   = 5'd3;
   localparam logic [4:0] CMD_PUSH_R = 5'd4;
   localparam logic [4:0] CMD_SMOV   = 5'd5;
   localparam logic [4:0] CMD_SMOV_R = 5'd6;
   localparam logic [4:0] CMD_POP    = 5'd7;
   localparam logic [4:0] CMD_CMP    = 5'd8;
   localparam logic [4:0] CMD_CMP_R  = 5'd9;
   localparam logic [4:0] CMD_ADD    = 5'd10;
   localparam logic [4:0] CMD_ADD_R  = 5'd11;
   localparam logic [4:0] CMD_SUB    = 5'd12;
   localparam logic [4:0] CMD_SUB_R  = 5'd13;
   localparam logic [4:0] CMD_MUL    = 5'd14;
   localparam logic [4:0] CMD_MUL_R  = 5'd15;
   localparam logic [4:0] CMD_DIV    = 5'd16;
   localparam logic [4:0] CMD_DIV_R  = 5'd17;

   // error codes
   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
   localparam logic [1:0] ERR_ZERO_DIV  = 2'd3;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_BASE = 3'd0;

   // width of a reduced stack address carried through the queue
   localparam int STK_ADDR_Q_W = 9;

   // front to back queue
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_MOV,
      OP_MOVS,
      OP_PUSH,
      OP_SMOV,
      OP_POP,
      OP_CMP,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } i8rse_op_kind_type;

   typedef struct packed {
      i8rse_op_kind_type        op;
      logic                     reg_form;
      logic [3:0]               dest_idx;
      logic [3:0]               src_idx;
      logic signed [7:0]        imm_value;
      logic [7:0]               stack_offset;
      logic [STK_ADDR_Q_W-1:0]  stack_addr;
   } i8rse_op_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } i8rse_q_stat_type;

   typedef struct packed {
      logic              start;
      logic signed [7:0] dividend;
      logic signed [7:0] divisor;
   } i8rse_div_req_type;

   typedef struct packed {
      logic        done;
      logic [7:0]  quotient;
   } i8rse_div_rsp_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC,
      BK_STACK,
      BK_DIV
   } i8rse_bk_state_type;

endpackage

`default_nettype wire

FILE: rtl/i8rse_front.sv
`default_nettype none

module i8rse_front #(
   parameter int STACK_DEPTH = 256,
   parameter int NUM_REGS    = 16
) (
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [4:0]              req_cmd,
   input  wire logic [3:0]              req_dest_reg,
   input  wire logic [3:0]              req_src_reg,
   input  wire logic signed [7:0]       req_imm_value,
   input  wire logic [7:0]              req_stack_offset,
   input  wire logic [7:0]              frame_base,
   input  wire logic                    clearing,
   input  wire i8rse_pkg::i8rse_q_stat_type q_stat,
   output logic                         q_push,
   output i8rse_pkg::i8rse_op_type      q_entry
);

   // register index modulo the register count, as a 16-entry table
   function automatic logic [3:0] reg_wrap(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      for (int k = 0; k < 16; k++) begin
         if (v == 4'(k)) r = 4'(k % NUM_REGS);
      end
      return r;
   endfunction

   // stack address modulo depth, by restoring subtraction of shifted depths
   function automatic logic [i8rse_pkg::STK_ADDR_Q_W-1:0] stk_wrap(
      input logic [i8rse_pkg::STK_ADDR_Q_W-1:0] x);
      logic [23:0] r;
      r = 24'(x);
      for (int k = 4; k >= 0; k--) begin
         if (r >= 24'(STACK_DEPTH * (1 << k))) r = r - 24'(STACK_DEPTH * (1 << k));
      end
      return i8rse_pkg::STK_ADDR_Q_W'(r);
   endfunction

   i8rse_pkg::i8rse_op_kind_type op_kind;
   logic                         reg_form;
   logic [i8rse_pkg::STK_ADDR_Q_W-1:0] frame_sum;

   always_comb begin
      op_kind  = i8rse_pkg::OP_NOP;
      reg_form = 1'b0;
      case (req_cmd)
         i8rse_pkg::CMD_MOV:    op_kind = i8rse_pkg::OP_MOV;
         i8rse_pkg::CMD_MOV_R: begin
            op_kind  = i8rse_pkg::OP_MOV;
            reg_form = 1'b1;
         end
         i8rse_pkg::CMD_MOVS:   op_kind = i8rse_pkg::OP_MOVS;
         i8rse_pkg::CMD_PUSH:   op_kind = i8rse_pkg::OP_PUSH;
         i8rse_pkg::CMD_PUSH_R: begin
            op_kind  = i8rse_pkg::OP_PUSH;
            reg_form = 1'b1;
         end
         i8rse_pkg::CMD_SMOV:   op_kind = i8rse_pkg::OP_SMOV;
         i8rse_pkg::CMD_SMOV_R: begin
            op_kind  = i8rse_pkg::OP_SMOV;
            reg_form = 1'b1;
         end
         i8rse_pkg::CMD_POP:    op_kind = i8rse_pkg::OP_POP;
         i8rse_pkg::CMD_CMP:    op_kind = i8rse_pkg::OP_CMP;
         i8rse_pkg::CMD_CMP_R: begin
            op_kind  = i8rse_pkg::OP_CMP;
            reg_form = 1'b1;
         end
         i8rse_pkg::CMD_ADD:    op_kind = i8rse_pkg::OP_ADD;
         i8rse_pkg::CMD_ADD_R: begin
            op_kind  = i8rse_pkg::OP_ADD;
            reg_form = 1'b1;
         end
         i8rse_pkg::CMD_SUB:    op_kind = i8rse_pkg::OP_SUB;
         i8rse_pkg::CMD_SUB_R: begin
            op_kind  = i8rse_pkg::OP_SUB;
            reg_form = 1'b1;
         end
         i8rse_pkg::CMD_MUL:    op_kind = i8rse_pkg::OP_MUL;
         i8rse_pkg::CMD_MUL_R: begin
            op_kind  = i8rse_pkg::OP_MUL;
            reg_form = 1'b1;
         end
         i8rse_pkg::CMD_DIV:    op_kind = i8rse_pkg::OP_DIV;
         i8rse_pkg::CMD_DIV_R: begin
            op_kind  = i8rse_pkg::OP_DIV;
            reg_form = 1'b1;
         end
         default: begin
            op_kind  = i8rse_pkg::OP_NOP;
            reg_form = 1'b0;
         end
      endcase
   end

   assign frame_sum = i8rse_pkg::STK_ADDR_Q_W'(frame_base)
                    + i8rse_pkg::STK_ADDR_Q_W'(req_stack_offset);

   always_comb begin
      q_entry.op           = op_kind;
      q_entry.reg_form     = reg_form;
      q_entry.dest_idx     = reg_wrap(req_dest_reg);
      q_entry.src_idx      = reg_wrap(req_src_reg);
      q_entry.imm_value    = req_imm_value;
      q_entry.stack_offset = req_stack_offset;
      q_entry.stack_addr   = (op_kind == i8rse_pkg::OP_SMOV)
                           ? stk_wrap(frame_sum)
                           : stk_wrap(i8rse_pkg::STK_ADDR_Q_W'(req_stack_offset));
   end

   // no intake while the stack is being cleared or the queue is full
   assign req_stall = q_stat.full | clearing;
   assign q_push    = req_valid & ~req_stall;

endmodule

`default_nettype wire

FILE: rtl/i8rse_fifo.sv
`default_nettype none

module i8rse_fifo (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire i8rse_pkg::i8rse_op_type  push_entry,
   input  wire logic                     pop,
   output i8rse_pkg::i8rse_op_type       head,
   output i8rse_pkg::i8rse_q_stat_type   stat
);

   i8rse_pkg::i8rse_op_type              entry_ff [i8rse_pkg::QUEUE_DEPTH];
   logic [i8rse_pkg::Q_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [i8rse_pkg::Q_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [i8rse_pkg::Q_CNT_W-1:0]        count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + i8rse_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + i8rse_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + i8rse_pkg::Q_CNT_W'(1);
      if (pop && !push) count_in = count_ff - i8rse_pkg::Q_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_entry;
   end

   assign head           = entry_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != '0);
   assign stat.full      = (count_ff == i8rse_pkg::Q_CNT_W'(i8rse_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: rtl/i8rse_div.sv
`default_nettype none

module i8rse_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire i8rse_pkg::i8rse_div_req_type req,
   output i8rse_pkg::i8rse_div_rsp_type     rsp
);

   logic       busy_ff, done_ff;
   logic [2:0] cnt_ff;
   logic [8:0] rem_ff;
   logic [7:0] quo_ff;
   logic [7:0] dv_ff;
   logic       neg_ff;
   logic [8:0] shifted;
   logic [9:0] trial;
   logic [7:0] mag_a, mag_b;

   // magnitudes; the most negative value maps to 128 unsigned
   assign mag_a = req.dividend[7] ? 8'(-req.dividend) : 8'(req.dividend);
   assign mag_b = req.divisor[7]  ? 8'(-req.divisor)  : 8'(req.divisor);

   // one quotient bit per cycle, restoring
   assign shifted = {rem_ff[7:0], quo_ff[7]};
   assign trial   = {1'b0, shifted} - {2'b00, dv_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd7;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         quo_ff <= mag_a;
         dv_ff  <= mag_b;
         neg_ff <= req.dividend[7] ^ req.divisor[7];
      end else if (busy_ff) begin
         if (!trial[9]) begin
            rem_ff <= trial[8:0];
            quo_ff <= {quo_ff[6:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            quo_ff <= {quo_ff[6:0], 1'b0};
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = neg_ff ? 8'(-quo_ff) : quo_ff;

endmodule

`default_nettype wire

FILE: rtl/i8rse_back.sv
`default_nettype none

module i8rse_back #(
   parameter int STACK_DEPTH = 256,
   parameter int NUM_REGS    = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire i8rse_pkg::i8rse_q_stat_type q_stat,
   input  wire i8rse_pkg::i8rse_op_type  q_head,
   output logic                          q_pop,
   output logic                          clearing,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [1:0]                    rsp_error_code,
   output logic signed [7:0]             rsp_compare_value,
   output logic signed [7:0]             rsp_dest_value
);

   localparam int SA_W   = $clog2(STACK_DEPTH);
   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int RIDX_W = $clog2(NUM_REGS);
   localparam int CMP_W  = (SP_W > 8) ? SP_W : 8;

   i8rse_pkg::i8rse_bk_state_type state_ff, state_in;
   i8rse_pkg::i8rse_op_type       cur_ff;

   // register file with valid bits, two registered read ports
   logic [7:0]        rf_mem [NUM_REGS];
   logic              rf_vld_ff [NUM_REGS];
   logic [7:0]        ra_ff, rb_ff;
   logic              ra_vld_ff, rb_vld_ff;

   // stack memory, one write and one registered read port
   logic [7:0]        st_mem [STACK_DEPTH];
   logic [7:0]        st_rd_ff;

   logic [SP_W-1:0]   sp_ff;
   logic [7:0]        cmp_ff;
   logic [SA_W-1:0]   clr_cnt_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_err_ff;
   logic [7:0]        rsp_cmp_ff, rsp_dest_ff;

   logic signed [7:0]  a_val, rb_val, b_val;
   logic [7:0]         sum_val, diff_val;
   logic signed [15:0] prod_val;
   logic               sp_full, sp_empty, acc_bad, go_stack, go_div, out_free, clr_last;

   logic              rf_we;
   logic [7:0]        rf_wd;
   logic              cmp_we;
   logic              st_we;
   logic [SA_W-1:0]   st_waddr;
   logic [7:0]        st_wd;
   logic              st_re;
   logic [SA_W-1:0]   st_raddr;
   logic              sp_inc, sp_dec;
   logic              div_start;
   logic              out_load;
   logic [1:0]        out_err;

   i8rse_pkg::i8rse_div_req_type div_req;
   i8rse_pkg::i8rse_div_rsp_type div_rsp;

   assign a_val    = ra_vld_ff ? signed'(ra_ff) : 8'sd0;
   assign rb_val   = rb_vld_ff ? signed'(rb_ff) : 8'sd0;
   assign b_val    = cur_ff.reg_form ? rb_val : cur_ff.imm_value;
   assign sum_val  = 8'(a_val + b_val);
   assign diff_val = 8'(a_val - b_val);
   assign prod_val = a_val * b_val;

   assign sp_full  = (sp_ff == SP_W'(STACK_DEPTH));
   assign sp_empty = (sp_ff == '0);
   assign acc_bad  = !sp_empty && (CMP_W'(sp_ff) < CMP_W'(cur_ff.stack_offset));
   assign go_stack = ((cur_ff.op == i8rse_pkg::OP_MOVS) && !acc_bad)
                  || ((cur_ff.op == i8rse_pkg::OP_POP) && !sp_empty);
   assign go_div   = (cur_ff.op == i8rse_pkg::OP_DIV) && (b_val != 8'sd0);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign clr_last = (clr_cnt_ff == SA_W'(STACK_DEPTH - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i8rse_pkg::BK_CLEAR: if (clr_last) state_in = i8rse_pkg::BK_IDLE;
         i8rse_pkg::BK_IDLE:  if (q_stat.not_empty) state_in = i8rse_pkg::BK_EXEC;
         i8rse_pkg::BK_EXEC: begin
            if (out_free) begin
               if (go_stack)    state_in = i8rse_pkg::BK_STACK;
               else if (go_div) state_in = i8rse_pkg::BK_DIV;
               else             state_in = i8rse_pkg::BK_IDLE;
            end
         end
         i8rse_pkg::BK_STACK: if (out_free) state_in = i8rse_pkg::BK_IDLE;
         i8rse_pkg::BK_DIV:   if (div_rsp.done && out_free) state_in = i8rse_pkg::BK_IDLE;
         default:             state_in = i8rse_pkg::BK_IDLE;
      endcase
   end

   // controls
   always_comb begin
      q_pop     = 1'b0;
      rf_we     = 1'b0;
      rf_wd     = a_val;
      cmp_we    = 1'b0;
      st_we     = 1'b0;
      st_waddr  = clr_cnt_ff;
      st_wd     = 8'd0;
      st_re     = 1'b0;
      st_raddr  = SA_W'(cur_ff.stack_addr);
      sp_inc    = 1'b0;
      sp_dec    = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      out_err   = i8rse_pkg::ERR_OK;
      case (state_ff)
         i8rse_pkg::BK_CLEAR: st_we = 1'b1;
         i8rse_pkg::BK_IDLE:  q_pop = q_stat.not_empty;
         i8rse_pkg::BK_EXEC: begin
            if (out_free) begin
               case (cur_ff.op)
                  i8rse_pkg::OP_MOV: begin
                     rf_we    = 1'b1;
                     rf_wd    = b_val;
                     out_load = 1'b1;
                  end
                  i8rse_pkg::OP_ADD: begin
                     rf_we    = 1'b1;
                     rf_wd    = sum_val;
                     out_load = 1'b1;
                  end
                  i8rse_pkg::OP_SUB: begin
                     rf_we    = 1'b1;
                     rf_wd    = diff_val;
                     out_load = 1'b1;
                  end
                  i8rse_pkg::OP_MUL: begin
                     rf_we    = 1'b1;
                     rf_wd    = prod_val[7:0];
                     out_load = 1'b1;
                  end
                  i8rse_pkg::OP_CMP: begin
                     cmp_we   = 1'b1;
                     out_load = 1'b1;
                  end
                  i8rse_pkg::OP_PUSH: begin
                     out_load = 1'b1;
                     if (sp_full) begin
                        out_err = i8rse_pkg::ERR_OVERFLOW;
                     end else begin
                        st_we    = 1'b1;
                        st_waddr = SA_W'(sp_ff);
                        st_wd    = b_val;
                        sp_inc   = 1'b1;
                     end
                  end
                  i8rse_pkg::OP_SMOV: begin
                     out_load = 1'b1;
                     if (acc_bad) begin
                        out_err = i8rse_pkg::ERR_UNDERFLOW;
                     end else begin
                        st_we    = 1'b1;
                        st_waddr = SA_W'(cur_ff.stack_addr);
                        st_wd    = b_val;
                     end
                  end
                  i8rse_pkg::OP_MOVS: begin
                     if (acc_bad) begin
                        out_err  = i8rse_pkg::ERR_UNDERFLOW;
                        out_load = 1'b1;
                     end else begin
                        st_re = 1'b1;
                     end
                  end
                  i8rse_pkg::OP_POP: begin
                     if (sp_empty) begin
                        out_err  = i8rse_pkg::ERR_UNDERFLOW;
                        out_load = 1'b1;
                     end else begin
                        st_re    = 1'b1;
                        st_raddr = SA_W'(sp_ff - SP_W'(1));
                        sp_dec   = 1'b1;
                     end
                  end
                  i8rse_pkg::OP_DIV: begin
                     if (go_div) begin
                        div_start = 1'b1;
                     end else begin
                        out_err  = i8rse_pkg::ERR_ZERO_DIV;
                        out_load = 1'b1;
                     end
                  end
                  default: out_load = 1'b1;
               endcase
            end
         end
         i8rse_pkg::BK_STACK: begin
            if (out_free) begin
               rf_we    = 1'b1;
               rf_wd    = st_rd_ff;
               out_load = 1'b1;
            end
         end
         i8rse_pkg::BK_DIV: begin
            if (div_rsp.done && out_free) begin
               rf_we    = 1'b1;
               rf_wd    = div_rsp.quotient;
               out_load = 1'b1;
            end
         end
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= i8rse_pkg::BK_CLEAR;
         clr_cnt_ff <= '0;
         sp_ff      <= '0;
         cmp_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == i8rse_pkg::BK_CLEAR) clr_cnt_ff <= clr_cnt_ff + SA_W'(1);
         if (sp_inc)      sp_ff <= sp_ff + SP_W'(1);
         else if (sp_dec) sp_ff <= sp_ff - SP_W'(1);
         if (cmp_we) cmp_ff <= diff_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) rf_vld_ff[i] <= 1'b0;
      end else if (rf_we) begin
         rf_vld_ff[RIDX_W'(cur_ff.dest_idx)] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) rf_mem[RIDX_W'(cur_ff.dest_idx)] <= rf_wd;
      if (q_pop) begin
         cur_ff    <= q_head;
         ra_ff     <= rf_mem[RIDX_W'(q_head.dest_idx)];
         rb_ff     <= rf_mem[RIDX_W'(q_head.src_idx)];
         ra_vld_ff <= rf_vld_ff[RIDX_W'(q_head.dest_idx)];
         rb_vld_ff <= rf_vld_ff[RIDX_W'(q_head.src_idx)];
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) st_mem[st_waddr] <= st_wd;
      if (st_re) st_rd_ff <= st_mem[st_raddr];
   end

   assign div_req.start    = div_start;
   assign div_req.dividend = a_val;
   assign div_req.divisor  = b_val;

   i8rse_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_err_ff  <= out_err;
         rsp_cmp_ff  <= cmp_we ? diff_val : cmp_ff;
         rsp_dest_ff <= rf_we ? rf_wd : a_val;
      end
   end

   assign clearing          = (state_ff == i8rse_pkg::BK_CLEAR);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_error_code    = rsp_err_ff;
   assign rsp_compare_value = signed'(rsp_cmp_ff);
   assign rsp_dest_value    = signed'(rsp_dest_ff);

endmodule

`default_nettype wire

FILE: rtl/int8_register_stack_execute.sv
// from queue head to result: moves, arithmetic, compare, push and frame stores pass
// IDLE and EXEC, stack loads and pops add STACK, divides wait in DIV (8-step divider)
// throughput: one transaction per back-end pass, set by the back-end sequencer
// reset: synchronous, active high; then a stack clearing pass over all STACK_DEPTH entries
// during which req_stall is high (register writes are still taken)
`default_nettype none

module int8_register_stack_execute #(
   parameter int STACK_DEPTH = 256,
   parameter int NUM_REGS    = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   // instruction transactions
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [4:0]                           req_cmd,
   input  wire logic [3:0]                           req_dest_reg,
   input  wire logic [3:0]                           req_src_reg,
   input  wire logic signed [7:0]                    req_imm_value,
   input  wire logic [7:0]                           req_stack_offset,

   // result transactions
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [1:0]                                rsp_error_code,
   output logic signed [7:0]                         rsp_compare_value,
   output logic signed [7:0]                         rsp_dest_value,

   // register port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [i8rse_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [i8rse_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [i8rse_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                      csr_pready
);

   // frame base register, written by the access phase of a register write
   logic [7:0] frame_base_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= '0;
      end else if (csr_wr && (csr_paddr == i8rse_pkg::CSR_FRAME_BASE)) begin
         frame_base_ff <= csr_pwdata[7:0];
      end
   end

   // read back; unmapped addresses read as zero
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == i8rse_pkg::CSR_FRAME_BASE) begin
         csr_prdata = i8rse_pkg::CSR_DATA_W'(frame_base_ff);
      end
   end

   // front: decode, index wrapping and stack address folding
   i8rse_pkg::i8rse_op_type     q_entry;
   i8rse_pkg::i8rse_op_type     q_head;
   i8rse_pkg::i8rse_q_stat_type q_stat;
   logic                        q_push;
   logic                        q_pop;
   logic                        clearing;

   i8rse_front #(
      .STACK_DEPTH (STACK_DEPTH),
      .NUM_REGS    (NUM_REGS)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_dest_reg     (req_dest_reg),
      .req_src_reg      (req_src_reg),
      .req_imm_value    (req_imm_value),
      .req_stack_offset (req_stack_offset),
      .frame_base       (frame_base_ff),
      .clearing         (clearing),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   // two-entry queue decouples intake from execution
   i8rse_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   // back: register file, stack, divider and result register
   i8rse_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .NUM_REGS    (NUM_REGS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_stat            (q_stat),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_error_code    (rsp_error_code),
      .rsp_compare_value (rsp_compare_value),
      .rsp_dest_value    (rsp_dest_value)
   );

   // checks
`include "int8_register_stack_execute_assert.svh"

   // the back end never takes from an empty queue
   `I8RSE_ASSERT_IMP(a_pop_not_empty, q_pop, q_stat.not_empty)
   // a pop is always followed by an execute cycle, never by a second pop
   `I8RSE_ASSERT_NXT(a_pop_spaced, q_pop, !q_pop)
   // nothing is queued or delivered while the stack is being cleared
   `I8RSE_ASSERT_IMP(a_clear_quiet, clearing, !q_stat.not_empty && !rsp_valid)

endmodule

`default_nettype wire
